### hw/rtl/iems_pkg.sv
package iems_pkg;

    // Queue depths
    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam int unsigned OUT_DEPTH       = 2;

    // Register reset value
    localparam logic [15:0] RECOVERY_RESET = 16'd5000;

    // Action codes
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Bits in one bus byte
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // Input beat
    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  addr_mode;
        logic [7:0]  device_byte;
        logic [16:0] mem_address;
        logic [7:0]  write_data;
        logic        sda_in;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_out_item;

    // Classified tick handed from front to back
    typedef struct packed {
        logic        req;
        logic        is_read;
        logic        wide17;
        logic        two_addr;
        logic [7:0]  device_byte;
        logic [16:0] mem_address;
        logic [7:0]  write_data;
        logic        sda_in;
    } t_cmd;

    // Bus sequencer phases
    typedef enum logic [15:0] {
        PH_IDLE     = 16'h0001,
        PH_START_A  = 16'h0002,
        PH_START_B  = 16'h0004,
        PH_TX_LO    = 16'h0008,
        PH_TX_HI    = 16'h0010,
        PH_ACK_LO   = 16'h0020,
        PH_ACK_HI   = 16'h0040,
        PH_RS_LO    = 16'h0080,
        PH_RX_LO    = 16'h0100,
        PH_RX_HI    = 16'h0200,
        PH_NACK_LO  = 16'h0400,
        PH_NACK_HI  = 16'h0800,
        PH_STOP_LO  = 16'h1000,
        PH_STOP_HI  = 16'h2000,
        PH_STOP_END = 16'h4000,
        PH_RECOVER  = 16'h8000
    } t_phase;

endpackage

### hw/rtl/iems_if.sv
// Input tick channel
interface iems_in_if;
    logic              valid;
    logic              ready;
    iems_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Result channel
interface iems_out_if;
    logic               valid;
    logic               ready;
    iems_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Recovery register write channel
interface iems_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/iems_fifo.sv
module iems_fifo #(
    parameter type         t_data = logic,
    parameter int unsigned DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_data o_data
);
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_data            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule

### hw/rtl/iems_front.sv
module iems_front #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    iems_in_if.sink        i_in,
    output logic           o_cmd_valid,
    output iems_pkg::t_cmd o_cmd,
    input  logic           i_cmd_pop
);
    import iems_pkg::*;

    t_cmd cls;

    // Classify the tick: decode request kind and address width
    always_comb begin
        cls.req         = (i_in.payload.action == ACT_WRITE) ||
                          (i_in.payload.action == ACT_READ);
        cls.is_read     = (i_in.payload.action == ACT_READ);
        cls.wide17      = i_in.payload.addr_mode[1];
        cls.two_addr    = (i_in.payload.addr_mode != 2'd0);
        cls.device_byte = i_in.payload.device_byte;
        cls.mem_address = i_in.payload.mem_address;
        cls.write_data  = i_in.payload.write_data;
        cls.sda_in      = i_in.payload.sda_in;
    end

    // Hold classified ticks until the sequencer takes them
    iems_fifo #(
        .t_data (t_cmd),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid),
        .i_data  (cls),
        .o_ready (i_in.ready),
        .i_pop   (i_cmd_pop),
        .o_valid (o_cmd_valid),
        .o_data  (o_cmd)
    );
endmodule

### hw/rtl/iems_back.sv
module iems_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  iems_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    iems_cfg_if.sink       i_cfg,
    iems_out_if.source     o_out
);
    import iems_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_shift, n_shift;
    logic [2:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_device, n_device;
    logic [16:0] r_address, n_address;
    logic [7:0]  r_data, n_data;
    logic        r_is_read, n_is_read;
    logic        r_wide17, n_wide17;
    logic        r_two_addr, n_two_addr;
    logic [15:0] r_wait, n_wait;
    logic [7:0]  r_rx, n_rx;
    logic [15:0] r_recovery;

    logic        fire;
    logic        out_ready;
    logic [2:0]  num_addr;
    logic [3:0]  bc_inc;
    logic [7:0]  rx_shift;
    logic [15:0] wait_dec;
    logic        scl, sda, drv, done;
    t_out_item   res;

    // Pick the byte to send for a given position in the transfer
    function automatic logic [7:0] byte_sel(
        input logic [2:0]  idx,
        input logic [2:0]  na,
        input logic        is_read,
        input logic        wide17,
        input logic [7:0]  device,
        input logic [16:0] address,
        input logic [7:0]  data
    );
        logic [7:0] dev_w;
        dev_w = wide17 ? {device[7:2], address[16], 1'b0} : {device[7:1], 1'b0};
        if (idx == 3'd0) begin
            byte_sel = dev_w;
        end else if (idx <= na) begin
            byte_sel = (na == 3'd2 && idx == 3'd1) ? address[15:8] : address[7:0];
        end else begin
            byte_sel = is_read ? {dev_w[7:1], 1'b1} : data;
        end
    endfunction

    assign fire      = i_cmd_valid && out_ready;
    assign o_cmd_pop = fire;
    assign num_addr  = r_two_addr ? 3'd2 : 3'd1;
    assign bc_inc    = r_bit_count + 1'b1;
    assign rx_shift  = {r_shift[6:0], i_cmd.sda_in};
    assign wait_dec  = r_wait - 1'b1;
    assign i_cfg.ready = 1'b1;

    // Step the bus sequence by one half-bit tick
    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_byte_index = r_byte_index;
        n_device     = r_device;
        n_address    = r_address;
        n_data       = r_data;
        n_is_read    = r_is_read;
        n_wide17     = r_wide17;
        n_two_addr   = r_two_addr;
        n_wait       = r_wait;
        n_rx         = r_rx;
        scl          = 1'b1;
        sda          = 1'b1;
        drv          = 1'b0;
        done         = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd.req) begin
                    n_device     = i_cmd.device_byte;
                    n_address    = i_cmd.mem_address;
                    n_data       = i_cmd.write_data;
                    n_is_read    = i_cmd.is_read;
                    n_wide17     = i_cmd.wide17;
                    n_two_addr   = i_cmd.two_addr;
                    n_byte_index = '0;
                    n_phase      = PH_START_A;
                end
            end
            PH_START_A: begin
                drv     = 1'b1;
                n_phase = PH_START_B;
            end
            PH_START_B: begin
                drv         = 1'b1;
                sda         = 1'b0;
                n_shift     = byte_sel(r_byte_index, num_addr, r_is_read, r_wide17,
                                       r_device, r_address, r_data);
                n_bit_count = '0;
                n_phase     = PH_TX_LO;
            end
            PH_TX_LO: begin
                scl     = 1'b0;
                drv     = 1'b1;
                sda     = r_shift[7];
                n_phase = PH_TX_HI;
            end
            PH_TX_HI: begin
                drv         = 1'b1;
                sda         = r_shift[7];
                n_shift     = {r_shift[6:0], 1'b0};
                n_bit_count = bc_inc;
                n_phase     = (bc_inc >= BYTE_BITS) ? PH_ACK_LO : PH_TX_LO;
            end
            PH_ACK_LO: begin
                scl     = 1'b0;
                n_phase = PH_ACK_HI;
            end
            PH_ACK_HI: begin
                // Wait with SCL high until the slave acknowledges
                if (!i_cmd.sda_in) begin
                    if (!r_is_read && r_byte_index >= num_addr + 3'd1) begin
                        n_phase = PH_STOP_LO;
                    end else if (r_is_read && r_byte_index == num_addr) begin
                        n_byte_index = r_byte_index + 1'b1;
                        n_phase      = PH_RS_LO;
                    end else if (r_is_read && r_byte_index > num_addr) begin
                        n_shift     = '0;
                        n_bit_count = '0;
                        n_phase     = PH_RX_LO;
                    end else begin
                        n_byte_index = r_byte_index + 1'b1;
                        n_shift      = byte_sel(r_byte_index + 1'b1, num_addr, r_is_read,
                                                r_wide17, r_device, r_address, r_data);
                        n_bit_count  = '0;
                        n_phase      = PH_TX_LO;
                    end
                end
            end
            PH_RS_LO: begin
                scl     = 1'b0;
                drv     = 1'b1;
                n_phase = PH_START_A;
            end
            PH_RX_LO: begin
                scl     = 1'b0;
                n_phase = PH_RX_HI;
            end
            PH_RX_HI: begin
                n_shift     = rx_shift;
                n_bit_count = bc_inc;
                if (bc_inc >= BYTE_BITS) begin
                    n_rx    = rx_shift;
                    n_phase = PH_NACK_LO;
                end else begin
                    n_phase = PH_RX_LO;
                end
            end
            PH_NACK_LO: begin
                scl     = 1'b0;
                drv     = 1'b1;
                n_phase = PH_NACK_HI;
            end
            PH_NACK_HI: begin
                drv     = 1'b1;
                n_phase = PH_STOP_LO;
            end
            PH_STOP_LO: begin
                scl     = 1'b0;
                drv     = 1'b1;
                sda     = 1'b0;
                n_phase = PH_STOP_HI;
            end
            PH_STOP_HI: begin
                drv     = 1'b1;
                sda     = 1'b0;
                n_phase = PH_STOP_END;
            end
            PH_STOP_END: begin
                drv  = 1'b1;
                done = 1'b1;
                if (!r_is_read && r_wide17 && r_recovery != '0) begin
                    n_wait  = r_recovery;
                    n_phase = PH_RECOVER;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_RECOVER: begin
                n_wait = wait_dec;
                if (wait_dec == '0) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Form the result beat
    always_comb begin
        res.scl_out   = scl;
        res.sda_out   = drv ? sda : 1'b1;
        res.sda_drive = drv;
        res.busy_res  = (n_phase != PH_IDLE);
        res.done_res  = done;
        res.read_data = n_rx;
    end

    // Control state and recovery register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_rx       <= '0;
            r_recovery <= RECOVERY_RESET;
        end else begin
            if (fire) begin
                r_phase <= n_phase;
                r_rx    <= n_rx;
            end
            if (i_cfg.valid) begin
                r_recovery <= i_cfg.payload;
            end
        end
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_byte_index <= n_byte_index;
            r_device     <= n_device;
            r_address    <= n_address;
            r_data       <= n_data;
            r_is_read    <= n_is_read;
            r_wide17     <= n_wide17;
            r_two_addr   <= n_two_addr;
            r_wait       <= n_wait;
        end
    end

    // Hold result beats until the sink takes them
    iems_fifo #(
        .t_data (t_out_item),
        .DEPTH  (OUT_DEPTH)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res),
        .o_ready (out_ready),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_data  (o_out.payload)
    );
endmodule

### hw/rtl/i2c_eeprom_master_sequencer_top.sv
// Path: an accepted tick beat passes the tick queue register, then the result buffer
// register, before its result beat can be taken by the sink.
// Throughput: one tick beat per cycle while the result buffer has room; a full buffer stalls the sequencer.
// Reset: i_rst_n synchronous, active low; empties both queues, sets the phase to idle,
// clears the received byte and loads the recovery register with 5000. No clearing pass.
module i2c_eeprom_master_sequencer_top #(
    parameter int unsigned QUEUE_DEPTH = iems_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iems_in_if.sink    i_in,
    iems_cfg_if.sink   i_cfg,
    iems_out_if.source o_out
);
    import iems_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    // Accept and classify ticks
    iems_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Run the bus sequence
    iems_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );
endmodule
